// File: design/bhst_pkg.sv
// Package for the bed heat soak timer: widths, reset values, register indexes,
// the reciprocal constant for the divide by 1000 and the controller command struct.
// No dependencies.
package bhst_pkg;

    localparam int ZONE_COUNT = 16;
    localparam logic [15:0] ZONE_BITS = (ZONE_COUNT >= 16) ? 16'hFFFF :
                                        16'((32'd1 << ZONE_COUNT) - 32'd1);

    localparam int BED_W    = 14;
    localparam int TARGET_W = 9;
    localparam int MASK_W   = 16;
    localparam int TIME_W   = 32;
    localparam int REM_W    = 22;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [REM_W-1:0] REMAIN_MAX = 22'd2147483;
    localparam logic [9:0]       MS_PER_S   = 10'd1000;
    // floor(x / 1000) == (x * DIV1000_MUL) >> DIV1000_SHIFT for every 32-bit x.
    localparam logic [28:0]      DIV1000_MUL   = 29'd274877907;
    localparam int               DIV1000_SHIFT = 38;

    localparam logic [8:0]  RST_MIN_SOAK_TEMP = 9'd60;
    localparam logic [6:0]  RST_NEAR_BAND     = 7'd15;
    localparam logic [11:0] RST_BASE_SOAK_S   = 12'd180;
    localparam logic [7:0]  RST_SOAK_S_PER_DEG = 8'd14;
    localparam logic        RST_ZONE_WATCH    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SOAK_TEMP  = 3'd0,
        CFG_NEAR_BAND      = 3'd1,
        CFG_BASE_SOAK_S    = 3'd2,
        CFG_SOAK_S_PER_DEG = 3'd3,
        CFG_ZONE_WATCH     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic ld_in;
        logic ld_prod;
        logic ld_scale;
        logic ld_div;
        logic commit;
    } t_dp_cmd;

endpackage

// File: design/bed_heat_soak_timer_core.sv
// Top level of the bed heat soak timer: stream ports, configuration port,
// controller and datapath. Depends on bhst_pkg, bhst_ctrl and bhst_dp.
//
// An update moves from its input transfer through the controller states S_PROD,
// S_SCALE, S_DIV and S_RESULT, and the next input is taken back in S_IDLE. The
// states follow the datapath sequence: temperature test and degree product,
// scaling to milliseconds, subtraction with the multiply by the reciprocal of
// 1000, then the result and state update. Only one update is in flight, but a
// new one is taken while the previous result still waits in the output
// register; the result update then waits until that register is free.
// Configuration writes are taken in every cycle and should only be made while
// the block is idle.
module bed_heat_soak_timer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // bed_temp [13:0], target_temp [22:14], zone_mask [38:23], now_ms [70:39]
    input  logic [bhst_pkg::IN_W-1:0]        i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // soak_ready [0], soak_done [1], remaining_seconds [23:2]
    output logic [bhst_pkg::OUT_W-1:0]       o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bhst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bhst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bhst_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    bhst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    bhst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: design/bhst_ctrl.sv
// Controller of the bed heat soak timer: sequences one update through the
// datapath stages and owns the output valid flag. Depends on bhst_pkg.
module bhst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bhst_pkg::t_dp_cmd o_cmd
);
    import bhst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PROD   = 5'b00010,
        S_SCALE  = 5'b00100,
        S_DIV    = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   commit;

    // The result slot is free when empty or when its transfer happens this cycle.
    assign commit = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_PROD;
            S_PROD:   n_state = S_SCALE;
            S_SCALE:  n_state = S_DIV;
            S_DIV:    n_state = S_RESULT;
            S_RESULT: if (commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.ld_in    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.ld_prod  = (r_state == S_PROD);
    assign o_cmd.ld_scale = (r_state == S_SCALE);
    assign o_cmd.ld_div   = (r_state == S_DIV);
    assign o_cmd.commit   = commit;

endmodule

// File: design/bhst_dp.sv
// Datapath of the bed heat soak timer: configuration registers, soak state,
// the near-target test, required soak time and the divide by 1000.
// Depends on bhst_pkg.
module bhst_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [bhst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bhst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [bhst_pkg::IN_W-1:0]        i_in_data,
    input  bhst_pkg::t_dp_cmd                i_cmd,
    output logic [bhst_pkg::OUT_W-1:0]       o_out_data
);
    import bhst_pkg::*;

    // Configuration
    logic [8:0]  r_min_temp;
    logic [6:0]  r_near_band;
    logic [11:0] r_base_s;
    logic [7:0]  r_rate;
    logic        r_zone_watch;

    // Soak state
    logic [TIME_W-1:0] r_start;
    logic              r_start_valid;
    logic              r_done;
    logic [MASK_W-1:0] r_last_mask;

    // Stage registers
    logic signed [BED_W-1:0] r_bed;
    logic [TARGET_W-1:0]     r_target;
    logic [MASK_W-1:0]       r_mask;
    logic [TIME_W-1:0]       r_now;
    logic                    r_keep;
    logic                    r_ge_min;
    logic [TIME_W-1:0]       r_elapsed;
    logic [16:0]             r_prod;
    logic [17:0]             r_sec;
    logic [27:0]             r_req_ms;
    logic                    r_pos;
    logic [60:0]             r_quot_prod;

    // Output register
    logic              r_out_ready;
    logic              r_out_done;
    logic [REM_W-1:0]  r_out_rem;

    logic signed [15:0] temp_diff;
    logic [15:0]        temp_abs;
    logic               near;
    logic               changed;
    logic               keep;
    logic [17:0]        sec;
    logic signed [33:0] ms_diff;
    logic [22:0]        quot;
    logic [REM_W-1:0]   rem_calc;
    logic               done_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp   <= RST_MIN_SOAK_TEMP;
            r_near_band  <= RST_NEAR_BAND;
            r_base_s     <= RST_BASE_SOAK_S;
            r_rate       <= RST_SOAK_S_PER_DEG;
            r_zone_watch <= RST_ZONE_WATCH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_SOAK_TEMP:  r_min_temp   <= i_cfg_data[8:0];
                CFG_NEAR_BAND:      r_near_band  <= i_cfg_data[6:0];
                CFG_BASE_SOAK_S:    r_base_s     <= i_cfg_data[11:0];
                CFG_SOAK_S_PER_DEG: r_rate       <= i_cfg_data[7:0];
                CFG_ZONE_WATCH:     r_zone_watch <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Near-target test and mask watch, on the registered input.
    assign temp_diff = $signed({{2{r_bed[BED_W-1]}}, r_bed})
                     - $signed({3'b000, r_target, 4'b0000});
    assign temp_abs  = temp_diff[15] ? 16'(-temp_diff) : temp_diff;
    assign near      = (r_target != '0) && (temp_abs < {5'b00000, r_near_band, 4'b0000});
    assign changed   = r_zone_watch && (r_mask != r_last_mask);
    assign keep      = near && !changed;

    assign sec = r_ge_min ? (18'(r_prod) + 18'(r_base_s)) : 18'd0;

    assign ms_diff = $signed({6'b000000, r_req_ms})
                   - $signed({{2{r_elapsed[TIME_W-1]}}, r_elapsed});

    assign quot = r_quot_prod[60:DIV1000_SHIFT];

    always_comb begin
        if (!r_pos) begin
            rem_calc = '0;
        end else if (quot > {1'b0, REMAIN_MAX}) begin
            rem_calc = REMAIN_MAX;
        end else begin
            rem_calc = quot[REM_W-1:0];
        end
    end

    assign done_new = r_done || (rem_calc == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_bed    <= i_in_data[13:0];
            r_target <= i_in_data[22:14];
            r_mask   <= i_in_data[38:23] & ZONE_BITS;
            r_now    <= i_in_data[70:39];
        end
        if (i_cmd.ld_prod) begin
            r_keep    <= keep;
            r_ge_min  <= (r_target >= r_min_temp);
            r_prod    <= 17'(r_target - r_min_temp) * 17'(r_rate);
            // A start latched in this update gives zero elapsed time.
            r_elapsed <= (keep && r_start_valid) ? (r_now - r_start) : '0;
        end
        if (i_cmd.ld_scale) begin
            r_sec    <= sec;
            r_req_ms <= 28'(sec * MS_PER_S);
        end
        if (i_cmd.ld_div) begin
            r_pos       <= !ms_diff[33] && (ms_diff != '0);
            r_quot_prod <= 61'(ms_diff[31:0]) * 61'(DIV1000_MUL);
        end
        if (i_cmd.commit) begin
            r_out_ready <= r_keep;
            r_out_done  <= r_keep && done_new;
            if (!r_keep) begin
                r_out_rem <= 22'(r_sec);
            end else begin
                r_out_rem <= done_new ? '0 : rem_calc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start       <= '0;
            r_start_valid <= 1'b0;
            r_done        <= 1'b0;
            r_last_mask   <= '0;
        end else if (i_cmd.commit) begin
            r_last_mask <= r_mask;
            if (r_keep) begin
                if (!r_start_valid) begin
                    r_start       <= r_now;
                    r_start_valid <= 1'b1;
                end
                r_done <= done_new;
            end else begin
                r_start       <= '0;
                r_start_valid <= 1'b0;
                r_done        <= 1'b0;
            end
        end
    end

    assign o_out_data = {r_out_rem, r_out_done, r_out_ready};

endmodule

// File: tb/sv/bhst_soak_checker.sv
`timescale 1ns / 100ps
// Result checker for the bed heat soak timer: follows the configuration, input and
// result channels, predicts each status and compares it field by field.
// Depends on bhst_pkg.
module bhst_soak_checker
    import bhst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [IN_W-1:0]       i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_W-1:0]      i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic             soak_ready;
        logic             soak_done;
        logic [REM_W-1:0] remaining;
    } t_soak_status;

    t_soak_status soak_status_q[$];

    // Register copies.
    logic [8:0]  min_soak;
    logic [6:0]  band;
    logic [11:0] base_s;
    logic [7:0]  per_degree;
    logic        zone_watch;

    // Soak state.
    logic [TIME_W-1:0] soak_start;
    logic              soak_started;
    logic              ready_flag;
    logic              done_flag;
    logic [MASK_W-1:0] prev_mask;

    int fails = 0;

    function automatic logic [REM_W-1:0] seconds_left(input logic [TARGET_W-1:0] target,
                                                      input logic [TIME_W-1:0]   now);
        longint                   need_ms;
        longint                   elapsed;
        longint                   left;
        logic signed [TIME_W-1:0] delta;
        need_ms = 0;
        elapsed = 0;
        if (done_flag) return '0;
        if (target >= min_soak) begin
            need_ms = (longint'(base_s) +
                       (longint'(target) - longint'(min_soak)) * longint'(per_degree)) * 1000;
        end
        // The wrapping difference is read as signed, so time running backwards
        // lengthens the soak.
        if (soak_started) begin
            delta   = now - soak_start;
            elapsed = delta;
        end
        left = need_ms - elapsed;
        if (left <= 0) return '0;
        left = left / 1000;
        if (left > longint'(REMAIN_MAX)) return REMAIN_MAX;
        return REM_W'(left);
    endfunction

    task automatic advance_soak(input logic [IN_W-1:0] item, output t_soak_status status);
        logic signed [BED_W-1:0] bed;
        logic [TARGET_W-1:0]     target;
        logic [MASK_W-1:0]       mask;
        logic [TIME_W-1:0]       now;
        int                      offset;
        logic                    near;
        logic                    restart;
        bed    = item[BED_W-1:0];
        target = item[BED_W +: TARGET_W];
        mask   = item[BED_W+TARGET_W +: MASK_W] & ZONE_BITS;
        now    = item[BED_W+TARGET_W+MASK_W +: TIME_W];
        offset = int'(bed) - int'(target) * 16;
        if (offset < 0) offset = -offset;
        near = (target != 0) && (offset < int'(band) * 16);
        // The mask is always tracked; only with zone watch on does a change restart.
        restart = 1'b0;
        if (mask != prev_mask) begin
            prev_mask = mask;
            restart   = zone_watch;
        end
        if (near && !restart) begin
            if (!soak_started) begin
                soak_start   = now;
                soak_started = 1'b1;
            end
            ready_flag = 1'b1;
            if (seconds_left(target, now) == 0) done_flag = 1'b1;
        end else begin
            soak_start   = '0;
            soak_started = 1'b0;
            ready_flag   = 1'b0;
            done_flag    = 1'b0;
        end
        status.soak_ready = ready_flag;
        status.soak_done  = done_flag;
        status.remaining  = seconds_left(target, now);
    endtask

    task automatic check_field(input string field, input logic [REM_W-1:0] want,
                               input logic [REM_W-1:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_soak_status want;
        t_soak_status got;
        if (!i_rst_n) begin
            min_soak     = RST_MIN_SOAK_TEMP;
            band         = RST_NEAR_BAND;
            base_s       = RST_BASE_SOAK_S;
            per_degree   = RST_SOAK_S_PER_DEG;
            zone_watch   = RST_ZONE_WATCH;
            soak_start   = '0;
            soak_started = 1'b0;
            ready_flag   = 1'b0;
            done_flag    = 1'b0;
            prev_mask    = '0;
            soak_status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_SOAK_TEMP:  min_soak   = i_cfg_data[$bits(min_soak)-1:0];
                    CFG_NEAR_BAND:      band       = i_cfg_data[$bits(band)-1:0];
                    CFG_BASE_SOAK_S:    base_s     = i_cfg_data[$bits(base_s)-1:0];
                    CFG_SOAK_S_PER_DEG: per_degree = i_cfg_data[$bits(per_degree)-1:0];
                    CFG_ZONE_WATCH:     zone_watch = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.soak_ready = i_out_data[0];
                got.soak_done  = i_out_data[1];
                got.remaining  = i_out_data[2 +: REM_W];
                if (soak_status_q.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer with nothing expected, got %h",
                             $time, i_out_data);
                end else begin
                    want = soak_status_q.pop_front();
                    check_field("soak_ready", REM_W'(want.soak_ready), REM_W'(got.soak_ready));
                    check_field("soak_done", REM_W'(want.soak_done), REM_W'(got.soak_done));
                    check_field("remaining_seconds", want.remaining, got.remaining);
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_soak(i_in_data, want);
                soak_status_q.push_back(want);
            end
        end
        o_pending    <= soak_status_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/tb_bed_heat_soak_timer_core.sv
`timescale 1ns / 100ps
// Testbench top for bed_heat_soak_timer_core: clock, reset, stimulus and verdict.
// Depends on bhst_pkg, the core and bhst_soak_checker.
module tb_bed_heat_soak_timer_core;
    import bhst_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / PHASES;
    localparam int DRAIN_CYCLES = 8;
    localparam int BED_MAX      = 2 ** (BED_W - 1) - 1;
    localparam int BED_MIN      = -(2 ** (BED_W - 1));
    localparam int TARGET_MAX   = 2 ** TARGET_W - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycles     = 0;
    int sink_hold  = 0;
    int calm_left  = 0;
    int items_sent = 0;

    logic [TIME_W-1:0] now_ms    = '0;
    logic [MASK_W-1:0] last_mask = '0;

    // Register values last written, used only to shape the stimulus.
    logic [8:0]  c_min  = RST_MIN_SOAK_TEMP;
    logic [6:0]  c_band = RST_NEAR_BAND;
    logic [11:0] c_base = RST_BASE_SOAK_S;
    logic [7:0]  c_rate = RST_SOAK_S_PER_DEG;
    logic        c_watch = RST_ZONE_WATCH;

    bed_heat_soak_timer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    bhst_soak_checker soak_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result receiver stalls at random.
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            i_m_axis_tready <= 1'b0;
            sink_hold       <= pause_len();
        end else begin
            i_m_axis_tready <= 1'b1;
            sink_hold       <= $urandom_range(0, 24);
        end
    end

    function automatic longint soak_need_ms(input int tgt);
        if (tgt < int'(c_min)) return 0;
        return (longint'(c_base) + longint'(tgt - int'(c_min)) * longint'(c_rate)) * 1000;
    endfunction

    task automatic send_fields(input int bed, input int tgt, input logic [MASK_W-1:0] mask,
                               input logic [TIME_W-1:0] now);
        int               pause;
        logic [BED_W-1:0] bed_bits;
        pause = 0;
        if (bed > BED_MAX) bed = BED_MAX;
        else if (bed < BED_MIN) bed = BED_MIN;
        bed_bits = BED_W'(bed);
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 60);
        else pause = pause_len();
        if (pause > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'({now, mask, TARGET_W'(tgt), bed_bits});
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        last_mask = mask;
        items_sent++;
    endtask

    // Hold the sender until every result is back and the core has settled.
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] word;
        keep = CFG_DATA_W'((1 << width) - 1);
        // Bits above the register width carry junk that the core must drop.
        word = (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input int min_t, input int band, input int base_s,
                              input int rate, input int watch);
        c_min   = 9'(min_t);
        c_band  = 7'(band);
        c_base  = 12'(base_s);
        c_rate  = 8'(rate);
        c_watch = 1'(watch);
        write_reg(CFG_MIN_SOAK_TEMP, int'(c_min), $bits(c_min));
        write_reg(CFG_NEAR_BAND, int'(c_band), $bits(c_band));
        write_reg(CFG_BASE_SOAK_S, int'(c_base), $bits(c_base));
        write_reg(CFG_SOAK_S_PER_DEG, int'(c_rate), $bits(c_rate));
        write_reg(CFG_ZONE_WATCH, int'(c_watch), $bits(c_watch));
        // An index past the last register must be ignored.
        write_reg(CFG_IDX_W'(int'(CFG_ZONE_WATCH) + $urandom_range(1, 3)), $urandom, CFG_DATA_W);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic noise_item();
        logic signed [BED_W-1:0] raw;
        logic [MASK_W-1:0]       mask;
        raw  = BED_W'($urandom);
        mask = ($urandom_range(0, 1) != 0) ? MASK_W'($urandom) : last_mask;
        if ($urandom_range(0, 3) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(0, 5000);
        send_fields(raw, $urandom_range(0, TARGET_MAX), mask, now_ms);
    endtask

    // A heat-up held near target with a steady mask, long enough in time for the
    // soak to finish, with the odd disturbance thrown in.
    task automatic soak_run();
        int                n;
        int                tgt;
        int                span;
        int                bed;
        int                k;
        int                r;
        longint            stride;
        logic [MASK_W-1:0] mask;
        n = $urandom_range(3, 18);
        if ($urandom_range(0, 1) != 0) tgt = int'(c_min) + $urandom_range(0, 40);
        else tgt = $urandom_range(1, TARGET_MAX);
        if (tgt > TARGET_MAX) tgt = TARGET_MAX;
        mask   = ($urandom_range(0, 3) == 0) ? MASK_W'($urandom) : last_mask;
        stride = soak_need_ms(tgt) / $urandom_range(1, n) + $urandom_range(0, 2000);
        span   = int'(c_band) * 16 - 1;
        for (k = 0; k < n; k++) begin
            bed    = tgt * 16 + int'($urandom_range(0, 2 * span)) - span;
            now_ms = now_ms + TIME_W'(stride) + $urandom_range(0, 999);
            r      = $urandom_range(0, 99);
            if (r < 3) begin
                bed = bed + (($urandom_range(0, 1) != 0) ? 1 : -1) *
                      (2 * span + 2 + int'($urandom_range(0, 200)));
            end else if (r < 6) begin
                mask = mask ^ (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
            end else if (r < 8) begin
                now_ms = now_ms - $urandom_range(1, 200000);
            end else if (r < 9) begin
                now_ms = now_ms + 32'h8000_0000;
            end
            send_fields(bed, tgt, mask, now_ms);
        end
    endtask

    task automatic random_phase(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(0, 99) < 35) noise_item();
            else soak_run();
            if ($urandom_range(0, 199) == 0) quiesce();
        end
    endtask

    initial begin : stimulus
        int phase;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values. The first update sees a nonzero mask against
        // the cleared one, so the soak cannot start yet.
        send_fields(1600, 100, 16'h0001, 32'd1000);
        send_fields(1600, 100, 16'h0001, 32'd2000);
        send_fields(1600 + 239, 100, 16'h0001, 32'd102000);
        send_fields(1600 - 239, 100, 16'h0001, 32'd702000);
        // Exactly on the band edge counts as outside, on either side.
        send_fields(1600 + 240, 100, 16'h0001, 32'd703000);
        send_fields(1600 - 240, 100, 16'h0001, 32'd704000);
        send_fields(1600, 100, 16'h0001, 32'd705000);
        send_fields(1600, 100, 16'h0001, 32'd1445000);
        // Done holds even when the clock steps back.
        send_fields(1600, 100, 16'h0001, 32'd945000);
        send_fields(-4096, TARGET_MAX, 16'h0001, 32'd946000);
        send_fields(BED_MAX, TARGET_MAX, 16'h0001, 32'hFFFF_FFF0);
        send_fields(BED_MAX, TARGET_MAX, 16'h0001, 32'h0000_0100);
        // Elapsed time of minus two to the 31 saturates the remaining seconds.
        send_fields(BED_MAX, TARGET_MAX, 16'h0001, 32'h7FFF_FFF0);
        send_fields(0, 0, 16'h0001, 32'h0000_0000);
        send_fields(BED_MIN, 0, 16'h0001, 32'hFFFF_FFFF);
        // Below the minimum temperature nothing is required, so done comes at once.
        send_fields(480, 30, 16'h0001, 32'd1000);
        send_fields(480, 30, 16'hFFFF, 32'd2000);
        send_fields(480, 30, 16'hFFFF, 32'd3000);
        send_fields(960, 60, 16'hFFFF, 32'd4000);
        send_fields(1600, 100, 16'h0000, 32'd5000);
        now_ms = 32'd6000;
        random_phase(PHASE_ITEMS);

        // Zone watch off, narrowest band, longest soak.
        quiesce();
        set_config(0, 1, 4095, 255, 0);
        send_fields(1600, 100, 16'h00FF, now_ms);
        send_fields(1615, 100, 16'hFF00, now_ms + 1000);
        send_fields(1616, 100, 16'hFF00, now_ms + 2000);
        send_fields(1585, 100, 16'h0F0F, now_ms + 3000);
        now_ms = now_ms + 4000;
        random_phase(PHASE_ITEMS);

        quiesce();
        set_config(TARGET_MAX, 100, 0, 0, 1);
        random_phase(PHASE_ITEMS);

        for (phase = 3; phase < PHASES; phase++) begin
            quiesce();
            set_config($urandom_range(0, TARGET_MAX), $urandom_range(1, 100),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) :
                                                     $urandom_range(0, 300),
                       $urandom_range(0, 255), $urandom_range(0, 1));
            random_phase(PHASE_ITEMS);
        end

        quiesce();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
